@@ rtl/b64enc_pkg.sv @@
// shared constants and helpers for the base64 line-wrap encoder
// no dependencies; imported by the top level and its checker
package b64enc_pkg;

    localparam int GROUPS_PER_LINE_DEF = 19;

    localparam logic [7:0] CHAR_PAD = 8'h3d;
    localparam logic [7:0] CHAR_CR  = 8'h0d;
    localparam logic [7:0] CHAR_LF  = 8'h0a;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // standard alphabet lookup
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + w;
        end else if (v < 6'd52) begin
            return 8'h61 + (w - 8'd26);
        end else if (v < 6'd62) begin
            return 8'h30 + (w - 8'd52);
        end else if (v == 6'd62) begin
            return 8'h2b;
        end else begin
            return 8'h2f;
        end
    endfunction

endpackage

@@ rtl/base64_encoder_line_wrap.sv @@
// base64 encoder, standard alphabet, optional CR LF after each line of groups
// depends on b64enc_pkg
//
// usage
//   input channel: i_valid / o_ready carry one message byte (i_data_byte) and a
//   flag for the final byte of the message (i_last_byte)
//   output channel: o_valid / i_ready carry one character per transfer, with
//   o_run_end on the last character of a byte and o_message_end on the last
//   character of the message
//   configuration: i_wrap_enable is written when i_wrap_enable_we is high
//   path: a byte's characters go to the pending buffer, then to the output
//   register; one character leaves per cycle while i_ready is high
//   throughput: a byte that makes one character is taken every cycle while
//   i_ready is high; a byte that makes more holds the input until its last
//   character has left the pending buffer for the output port
//   reset: encoder state, line counter and wrap enable go to zero, both
//   channels empty
//   stall: when i_ready is low the output register holds; the pending
//   character buffer keeps one byte's worth, then o_ready drops
module base64_encoder_line_wrap #(
    parameter int GROUPS_PER_LINE = b64enc_pkg::GROUPS_PER_LINE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wrap_enable_we,
    input  logic       i_wrap_enable,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_end,
    output logic       o_message_end
);
    import b64enc_pkg::*;

    localparam logic [5:0] GROUPS_LIM = 6'(GROUPS_PER_LINE);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [4:0] r_lgc, n_lgc;
    logic       r_wrap;

    logic [7:0] r_buf [4];
    logic [7:0] n_buf [4];
    logic [1:0] r_top, n_top;
    logic [1:0] r_idx;
    logic       r_bvalid;
    logic       r_blast;

    logic       r_ovalid;
    logic [7:0] r_ochar;
    logic       r_orun;
    logic       r_omsg;

    logic       in_xfer;
    logic       out_free;
    logic       buf_pop;
    logic       buf_at_top;
    logic [5:0] lgc_inc;

    assign out_free   = !r_ovalid || i_ready;
    assign buf_at_top = (r_idx == r_top);
    assign buf_pop    = r_bvalid && out_free;
    assign o_ready    = !r_bvalid || (buf_pop && buf_at_top);
    assign in_xfer    = i_valid && o_ready;
    assign lgc_inc    = {1'b0, r_lgc} + 6'd1;

    // per-byte encoding of up to four characters
    always_comb begin
        n_phase = r_phase;
        n_carry = r_carry;
        n_lgc   = r_lgc;
        n_top   = 2'd0;
        for (int k = 0; k < 4; k++) begin
            n_buf[k] = CHAR_PAD;
        end
        unique case (r_phase)
            PHASE_SECOND: begin
                n_buf[0] = b64_sym({r_carry[1:0], i_data_byte[7:4]});
                n_carry  = i_data_byte[3:0];
                n_phase  = PHASE_THIRD;
                if (i_last_byte) begin
                    n_buf[1] = b64_sym({i_data_byte[3:0], 2'b00});
                    n_top    = 2'd2;
                end
            end
            PHASE_THIRD: begin
                n_buf[0] = b64_sym({r_carry, i_data_byte[7:6]});
                n_buf[1] = b64_sym(i_data_byte[5:0]);
                n_carry  = 4'd0;
                n_phase  = PHASE_FIRST;
                n_top    = 2'd1;
                if (lgc_inc >= GROUPS_LIM) begin
                    n_lgc = 5'd0;
                    if (r_wrap) begin
                        n_buf[2] = CHAR_CR;
                        n_buf[3] = CHAR_LF;
                        n_top    = 2'd3;
                    end
                end else begin
                    n_lgc = lgc_inc[4:0];
                end
            end
            default: begin
                n_buf[0] = b64_sym(i_data_byte[7:2]);
                n_carry  = {2'b00, i_data_byte[1:0]};
                n_phase  = PHASE_SECOND;
                if (i_last_byte) begin
                    n_buf[1] = b64_sym({i_data_byte[1:0], 4'b0000});
                    n_top    = 2'd3;
                end
            end
        endcase
        if (i_last_byte) begin
            n_phase = PHASE_FIRST;
            n_carry = 4'd0;
            n_lgc   = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PHASE_FIRST;
            r_carry  <= 4'd0;
            r_lgc    <= 5'd0;
            r_wrap   <= 1'b0;
            r_bvalid <= 1'b0;
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_wrap_enable_we) begin
                r_wrap <= i_wrap_enable;
            end
            if (in_xfer) begin
                r_phase  <= n_phase;
                r_carry  <= n_carry;
                r_lgc    <= n_lgc;
                r_bvalid <= 1'b1;
                r_idx    <= 2'd0;
            end else if (buf_pop) begin
                if (buf_at_top) begin
                    r_bvalid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
            if (out_free) begin
                r_ovalid <= r_bvalid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buf   <= n_buf;
            r_top   <= n_top;
            r_blast <= i_last_byte;
        end
        if (out_free) begin
            r_ochar <= r_buf[r_idx];
            r_orun  <= buf_at_top;
            r_omsg  <= buf_at_top && r_blast;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_char    = r_ochar;
    assign o_run_end     = r_orun;
    assign o_message_end = r_omsg;

endmodule

@@ rtl/b64enc_checker.sv @@
// port-level checks for base64_encoder_line_wrap, bound to the top level
// depends on b64enc_pkg
module b64enc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_char,
    input logic       o_run_end,
    input logic       o_message_end
);
    import b64enc_pkg::*;

    // output holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char)
            && $stable(o_run_end) && $stable(o_message_end))
        else $error("output changed while stalled");

    a_msg_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_end |-> o_run_end)
        else $error("message end without run end");

    // line break goes out as one unbroken pair
    a_cr_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_out_char == CHAR_CR |=> o_valid && o_out_char == CHAR_LF)
        else $error("CR not followed by LF");

    // a pad that does not end the byte is followed by a second pad at once
    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_out_char == CHAR_PAD && !o_run_end
            |=> o_valid && o_out_char == CHAR_PAD && o_run_end)
        else $error("broken pad pair");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind base64_encoder_line_wrap b64enc_checker u_b64enc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_char    (o_out_char),
    .o_run_end     (o_run_end),
    .o_message_end (o_message_end)
);

@@ bench/tb_base64_encoder_line_wrap.sv @@
// self-checking bench for base64_encoder_line_wrap: byte stream in, characters out
// drives random valid/ready gaps on both channels and checks against an in-bench encoder
// depends on b64enc_pkg and the rtl top level
module tb_base64_encoder_line_wrap;
    import b64enc_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_BYTES   = 91;

    localparam logic [511:0] B64_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       msg_end;
    } char_res_t;

    typedef char_res_t res_set_t [4];

    typedef enum logic {ROW_BYTE, ROW_WRAP} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic        wrap_val;
        int          n_typed;
        logic [31:0] typed;
    } stim_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_wrap_enable_we;
    logic       i_wrap_enable;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_char;
    logic       o_run_end;
    logic       o_message_end;

    // encoder shadow state
    logic [1:0] enc_phase;
    logic [3:0] enc_carry;
    logic [4:0] enc_groups;
    logic       wrap_shadow;

    char_res_t  pending_chars[$];
    stim_row_t  dir_rows[$];

    int          tx_typed_n;
    logic [31:0] tx_typed;
    bit          tx_no_gaps;
    bit          rx_no_gaps;
    bit          rx_hold_req;

    int fails;
    int cycle_count;
    int n_bytes;
    int n_msgs;
    int n_chars;
    int n_breaks;
    int n_cfg;

    base64_encoder_line_wrap dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wrap_enable_we (i_wrap_enable_we),
        .i_wrap_enable    (i_wrap_enable),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_char       (o_out_char),
        .o_run_end        (o_run_end),
        .o_message_end    (o_message_end)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        return B64_ALPHA[8 * (63 - v) +: 8];
    endfunction

    function automatic void put_char(inout res_set_t r, inout int n, input logic [7:0] ch);
        r[n].ch      = ch;
        r[n].run_end = 1'b0;
        r[n].msg_end = 1'b0;
        n = n + 1;
    endfunction

    function automatic int encode_byte(input logic [7:0] b, input logic l,
                                       output res_set_t r);
        int n;
        n = 0;
        for (int k = 0; k < 4; k++) begin
            r[k] = '0;
        end
        if (enc_phase == PHASE_SECOND) begin
            put_char(r, n, alpha_char({enc_carry[1:0], b[7:4]}));
            enc_carry = b[3:0];
            enc_phase = PHASE_THIRD;
            if (l) begin
                put_char(r, n, alpha_char({b[3:0], 2'b00}));
                put_char(r, n, CHAR_PAD);
            end
        end else if (enc_phase == PHASE_THIRD) begin
            put_char(r, n, alpha_char({enc_carry, b[7:6]}));
            put_char(r, n, alpha_char(b[5:0]));
            enc_carry = '0;
            enc_phase = PHASE_FIRST;
            if (int'(enc_groups) + 1 >= GROUPS_PER_LINE_DEF) begin
                enc_groups = '0;
                if (wrap_shadow) begin
                    put_char(r, n, CHAR_CR);
                    put_char(r, n, CHAR_LF);
                end
            end else begin
                enc_groups = enc_groups + 5'd1;
            end
        end else begin
            put_char(r, n, alpha_char(b[7:2]));
            enc_carry = {2'b00, b[1:0]};
            enc_phase = PHASE_SECOND;
            if (l) begin
                put_char(r, n, alpha_char({b[1:0], 4'b0000}));
                put_char(r, n, CHAR_PAD);
                put_char(r, n, CHAR_PAD);
            end
        end
        r[n - 1].run_end = 1'b1;
        if (l) begin
            r[n - 1].msg_end = 1'b1;
            enc_phase  = PHASE_FIRST;
            enc_carry  = '0;
            enc_groups = '0;
        end
        return n;
    endfunction

    always @(posedge i_clk) begin : monitor
        int        n;
        res_set_t  got;
        char_res_t e;
        if (!i_rst_n) begin
            enc_phase   = PHASE_FIRST;
            enc_carry   = '0;
            enc_groups  = '0;
            wrap_shadow = 1'b0;
        end else begin
            if (i_wrap_enable_we) begin
                wrap_shadow = i_wrap_enable;
            end
            if (i_valid && o_ready) begin
                n = encode_byte(i_data_byte, i_last_byte, got);
                if (tx_typed_n != 0) begin
                    for (int k = 0; k < tx_typed_n; k++) begin
                        e.ch      = tx_typed[8 * (tx_typed_n - 1 - k) +: 8];
                        e.run_end = (k == tx_typed_n - 1);
                        e.msg_end = e.run_end && i_last_byte;
                        pending_chars.push_back(e);
                    end
                end else begin
                    for (int k = 0; k < n; k++) begin
                        pending_chars.push_back(got[k]);
                    end
                end
            end
            if (o_valid && i_ready) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected character transfer: out_char %02h", o_out_char);
                    fails++;
                end else begin
                    e = pending_chars.pop_front();
                    n_chars++;
                    if (o_out_char == CHAR_LF) begin
                        n_breaks++;
                    end
                    if (o_out_char !== e.ch) begin
                        $error("out_char mismatch: expected %02h, actual %02h",
                               e.ch, o_out_char);
                        fails++;
                    end
                    if (o_run_end !== e.run_end) begin
                        $error("run_end mismatch: expected %0b, actual %0b",
                               e.run_end, o_run_end);
                        fails++;
                    end
                    if (o_message_end !== e.msg_end) begin
                        $error("message_end mismatch: expected %0b, actual %0b",
                               e.msg_end, o_message_end);
                        fails++;
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // output side: ready runs broken by random stalls, plus one long hold-off on request
    initial begin : receiver
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                gap = rx_no_gaps ? 0 : pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic l, input int tn,
                             input logic [31:0] tc);
        int gap;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        tx_typed_n  <= tn;
        tx_typed    <= tc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_bytes++;
        if (l) begin
            n_msgs++;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_wrap(input logic v);
        wait_drained();
        i_wrap_enable_we <= 1'b1;
        i_wrap_enable    <= v;
        @(posedge i_clk);
        i_wrap_enable_we <= 1'b0;
        n_cfg++;
    endtask

    task automatic send_random(input int len, input logic ends);
        for (int k = 0; k < len; k++) begin
            push_byte(8'($urandom_range(0, 255)), ends && (k == len - 1), 0, '0);
        end
    endtask

    task automatic add_byte(input logic [7:0] d, input logic l, input int tn,
                            input logic [31:0] tc);
        stim_row_t row;
        row.kind     = ROW_BYTE;
        row.data     = d;
        row.last     = l;
        row.wrap_val = 1'b0;
        row.n_typed  = tn;
        row.typed    = tc;
        dir_rows.push_back(row);
    endtask

    task automatic add_wrap(input logic v);
        stim_row_t row;
        row.kind     = ROW_WRAP;
        row.data     = '0;
        row.last     = 1'b0;
        row.wrap_val = v;
        row.n_typed  = 0;
        row.typed    = '0;
        dir_rows.push_back(row);
    endtask

    initial begin : sender
        int len;
        int n_rand;
        i_rst_n          = 1'b0;
        i_wrap_enable_we = 1'b0;
        i_wrap_enable    = 1'b0;
        i_valid          = 1'b0;
        i_data_byte      = '0;
        i_last_byte      = 1'b0;
        tx_typed_n       = 0;
        tx_typed         = '0;
        tx_no_gaps       = 1'b0;
        rx_no_gaps       = 1'b0;
        rx_hold_req      = 1'b0;
        fails            = 0;
        cycle_count      = 0;
        n_bytes          = 0;
        n_msgs           = 0;
        n_chars          = 0;
        n_breaks         = 0;
        n_cfg            = 0;
        n_rand           = 0;

        add_byte(8'h00, 1'b1, 4, "AA==");
        add_byte(8'hff, 1'b1, 4, "/w==");
        add_byte(8'hff, 1'b0, 1, "/");
        add_byte(8'hff, 1'b0, 1, "/");
        add_byte(8'hff, 1'b1, 2, "//");
        add_byte(8'h00, 1'b0, 1, "A");
        add_byte(8'h00, 1'b1, 3, "AA=");
        add_byte(8'h4d, 1'b0, 0, '0);
        add_byte(8'h61, 1'b0, 0, '0);
        add_byte(8'h6e, 1'b0, 0, '0);
        add_byte(8'h80, 1'b1, 0, '0);
        add_wrap(1'b1);
        add_byte(8'h5a, 1'b0, 0, '0);
        add_byte(8'ha5, 1'b1, 0, '0);
        add_byte(8'h01, 1'b0, 0, '0);
        add_byte(8'h02, 1'b0, 0, '0);
        add_byte(8'h03, 1'b0, 0, '0);
        add_byte(8'hfe, 1'b0, 0, '0);
        add_wrap(1'b0);
        add_byte(8'hfd, 1'b0, 0, '0);
        add_byte(8'h7f, 1'b1, 0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRAP) begin
                set_wrap(dir_rows[i].wrap_val);
            end else begin
                push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].n_typed,
                          dir_rows[i].typed);
            end
        end

        // full line ending the message, wrap turned on partway through it;
        // the rest is pushed back-to-back into a stalled output
        set_wrap(1'b0);
        send_random(30, 1'b0);
        set_wrap(1'b1);
        rx_hold_req = 1'b1;
        tx_no_gaps  = 1'b1;
        send_random(3 * GROUPS_PER_LINE_DEF - 30, 1'b1);
        tx_no_gaps  = 1'b0;
        n_rand += 3 * GROUPS_PER_LINE_DEF;

        while (n_rand < RANDOM_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 8);
            if (len > RANDOM_BYTES - n_rand) begin
                len = RANDOM_BYTES - n_rand;
            end
            if ($urandom_range(0, 3) == 0) begin
                set_wrap(1'($urandom_range(0, 1)));
            end
            tx_no_gaps = ($urandom_range(0, 4) == 0);
            rx_no_gaps = tx_no_gaps;
            send_random(len, 1'b1);
            n_rand += len;
        end
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $error("%0d expected characters never arrived", pending_chars.size());
            fails++;
        end

        $display("encoded %0d bytes in %0d messages into %0d characters, %0d line breaks",
                 n_bytes, n_msgs, n_chars, n_breaks);
        $display("wrap enable written %0d times, %0d mismatches", n_cfg, fails);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
